// File: rtl/clook_pkg.sv
// shared types and constants for the c-look request scheduler
// no dependencies

package clook_pkg;

  localparam int MAX_REQUESTS_DEF  = 32;
  localparam int CYLINDER_BITS_DEF = 16;

  localparam int CYL_W  = 16;
  localparam int MOVE_W = 18;
  localparam logic [MOVE_W-1:0] MOVE_MAX = 18'h3FFFF;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_HEAD,
    ST_SELECT,
    ST_STEP,
    ST_PUT
  } state_t;

endpackage

// File: rtl/clook_disk_request_scheduler.sv
// c-look disk request scheduler: request store memory, scan sequencer, output register
// depends on clook_pkg
//
// Usage:
//   Input channel (in_valid / in_stall): in_command = CMD_LOAD stores in_cylinder as a
//   pending request (dropped once MAX_REQUESTS are held); in_command = CMD_RUN gives the
//   head cylinder and starts a schedule. A load produces no result.
//   Result channel (out_valid / out_stall): one transfer per served cylinder, the head
//   first, then the c-look order; out_last marks the final transfer, which alone carries
//   out_total_movement (zero on the others).
//   Sequence: a run with n stored requests makes one counting scan of the store, outputs the
//   head, then for each request makes a full scan of the store to pick the next entry,
//   computes the step distance in a separate state and then puts the output.
//   New items are refused while a run is in progress; loads are taken while the last
//   result still waits in the output register.
//   Reset empties the store (count to zero) and clears out_valid; a run also
//   empties the store. A stalled result holds; the scheduler waits at the next output.

module clook_disk_request_scheduler #(
  parameter int MAX_REQUESTS  = clook_pkg::MAX_REQUESTS_DEF,
  parameter int CYLINDER_BITS = clook_pkg::CYLINDER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [clook_pkg::CYL_W-1:0]    in_cylinder,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [clook_pkg::CYL_W-1:0]    out_served_cylinder,
  output logic [clook_pkg::MOVE_W-1:0]   out_total_movement,
  output logic                           out_last
);

  localparam int CB = CYLINDER_BITS;
  localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int KW = 1 + CB + IW;
  localparam int SW = ((CB > clook_pkg::MOVE_W) ? CB : clook_pkg::MOVE_W) + 1;

  clook_pkg::state_t state_r, state_nxt;

  logic [CB-1:0] mem [MAX_REQUESTS];
  logic [CB-1:0] mem_q_r;
  logic [IW-1:0] rd_idx_r;
  logic          mem_we;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] below_r, below_nxt;
  logic [CW-1:0] emit_r, emit_nxt;
  logic [CB-1:0] head_r, head_nxt;
  logic          first_r, first_nxt;
  logic          found_r, found_nxt;
  logic [KW-1:0] best_key_r, best_key_nxt;
  logic [CB-1:0] best_val_r, best_val_nxt;
  logic [KW-1:0] prev_key_r, prev_key_nxt;
  logic [CB-1:0] prev_val_r, prev_val_nxt;
  logic [CB-1:0] diff_r, diff_nxt;
  logic [clook_pkg::MOVE_W-1:0] total_r, total_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [clook_pkg::CYL_W-1:0]  out_cyl_r, out_cyl_nxt;
  logic [clook_pkg::MOVE_W-1:0] out_total_r, out_total_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [CB-1:0] in_cyl_m;
  logic          in_xfer;
  logic          out_free;
  logic          scan_end;
  logic          scan_proc;
  logic          sweep_up;
  logic          q_below;
  logic [KW-1:0] key_q;
  logic          take_q;
  logic [CW-1:0] emit_inc;
  logic          put_last;
  logic [SW-1:0] move_sum;
  logic [clook_pkg::MOVE_W-1:0] move_sat;

  assign in_cyl_m  = CB'(in_cylinder);
  assign in_stall  = (state_r != clook_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_end  = (addr_r == n_r);
  assign scan_proc = (addr_r != '0);
  assign sweep_up  = ({1'b0, n_r} > {below_r, 1'b0});
  assign q_below   = (mem_q_r < head_r);
  assign key_q     = sweep_up ? {q_below, mem_q_r, rd_idx_r} : {!q_below, ~mem_q_r, rd_idx_r};
  assign take_q    = (first_r || (key_q > prev_key_r)) && (!found_r || (key_q < best_key_r));
  assign emit_inc  = emit_r + CW'(1);
  assign put_last  = (emit_inc == n_r);
  assign move_sum  = SW'(total_r) + SW'(diff_r);
  assign move_sat  = (move_sum > SW'(clook_pkg::MOVE_MAX)) ? clook_pkg::MOVE_MAX
                                                            : move_sum[clook_pkg::MOVE_W-1:0];

  // request store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IW-1:0]] <= in_cyl_m;
    end
    mem_q_r  <= mem[addr_r[IW-1:0]];
    rd_idx_r <= addr_r[IW-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      clook_pkg::ST_IDLE: begin
        if (in_xfer && (in_command == clook_pkg::CMD_RUN)) begin
          state_nxt = clook_pkg::ST_COUNT;
        end
      end
      clook_pkg::ST_COUNT: begin
        if (scan_end) begin
          state_nxt = clook_pkg::ST_HEAD;
        end
      end
      clook_pkg::ST_HEAD: begin
        if (out_free) begin
          state_nxt = (n_r == '0) ? clook_pkg::ST_IDLE : clook_pkg::ST_SELECT;
        end
      end
      clook_pkg::ST_SELECT: begin
        if (scan_end) begin
          state_nxt = clook_pkg::ST_STEP;
        end
      end
      clook_pkg::ST_STEP: begin
        state_nxt = clook_pkg::ST_PUT;
      end
      clook_pkg::ST_PUT: begin
        if (out_free) begin
          state_nxt = put_last ? clook_pkg::ST_IDLE : clook_pkg::ST_SELECT;
        end
      end
      default: begin
        state_nxt = clook_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and output register
  always_comb begin
    mem_we        = 1'b0;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    addr_nxt      = addr_r;
    below_nxt     = below_r;
    emit_nxt      = emit_r;
    head_nxt      = head_r;
    first_nxt     = first_r;
    found_nxt     = found_r;
    best_key_nxt  = best_key_r;
    best_val_nxt  = best_val_r;
    prev_key_nxt  = prev_key_r;
    prev_val_nxt  = prev_val_r;
    diff_nxt      = diff_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cyl_nxt   = out_cyl_r;
    out_total_nxt = out_total_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      clook_pkg::ST_IDLE: begin
        addr_nxt = '0;
        if (in_xfer) begin
          if (in_command == clook_pkg::CMD_RUN) begin
            head_nxt  = in_cyl_m;
            n_nxt     = cnt_r;
            cnt_nxt   = '0;
            below_nxt = '0;
          end else if (cnt_r < CW'(MAX_REQUESTS)) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      clook_pkg::ST_COUNT: begin
        addr_nxt = scan_end ? '0 : addr_r + CW'(1);
        if (scan_proc && q_below) begin
          below_nxt = below_r + CW'(1);
        end
      end
      clook_pkg::ST_HEAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cyl_nxt   = clook_pkg::CYL_W'(head_r);
          out_total_nxt = '0;
          out_last_nxt  = (n_r == '0);
          prev_val_nxt  = head_r;
          first_nxt     = 1'b1;
          found_nxt     = 1'b0;
          total_nxt     = '0;
          emit_nxt      = '0;
          addr_nxt      = '0;
        end
      end
      clook_pkg::ST_SELECT: begin
        addr_nxt = scan_end ? '0 : addr_r + CW'(1);
        if (scan_proc && take_q) begin
          found_nxt    = 1'b1;
          best_key_nxt = key_q;
          best_val_nxt = mem_q_r;
        end
      end
      clook_pkg::ST_STEP: begin
        diff_nxt = (best_val_r > prev_val_r) ? best_val_r - prev_val_r
                                             : prev_val_r - best_val_r;
      end
      clook_pkg::ST_PUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cyl_nxt   = clook_pkg::CYL_W'(best_val_r);
          out_total_nxt = put_last ? move_sat : '0;
          out_last_nxt  = put_last;
          total_nxt     = move_sat;
          prev_key_nxt  = best_key_r;
          prev_val_nxt  = best_val_r;
          first_nxt     = 1'b0;
          found_nxt     = 1'b0;
          emit_nxt      = emit_inc;
          addr_nxt      = '0;
        end
      end
      default: begin
        addr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clook_pkg::ST_IDLE;
      cnt_r       <= '0;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    below_r     <= below_nxt;
    emit_r      <= emit_nxt;
    head_r      <= head_nxt;
    first_r     <= first_nxt;
    found_r     <= found_nxt;
    best_key_r  <= best_key_nxt;
    best_val_r  <= best_val_nxt;
    prev_key_r  <= prev_key_nxt;
    prev_val_r  <= prev_val_nxt;
    diff_r      <= diff_nxt;
    total_r     <= total_nxt;
    out_cyl_r   <= out_cyl_nxt;
    out_total_r <= out_total_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_served_cylinder = out_cyl_r;
  assign out_total_movement  = out_total_r;
  assign out_last            = out_last_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_REQUESTS))
    else $error("request count above capacity");

  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_command == clook_pkg::CMD_RUN)) |=> (cnt_r == '0))
    else $error("run did not clear the store");

  a_put_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clook_pkg::ST_PUT) |-> found_r)
    else $error("no entry selected for output");

  a_select_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clook_pkg::ST_SELECT) |-> (emit_r < n_r))
    else $error("selection scan with nothing left to serve");
`endif

endmodule

// File: sim/tb_clook_disk_request_scheduler.sv
// self-checking testbench for the c-look disk request scheduler: directed table, then random
// load/run sequences, with every served cylinder checked against a behavioral order predictor
// depends on clook_pkg and rtl/clook_disk_request_scheduler.sv

module tb_clook_disk_request_scheduler;

  localparam int DIRECTED_N  = 19;
  localparam int TOTAL_ITEMS = 460;
  localparam int QUIET_TAIL  = 60;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 100;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                         cmd;
    logic [clook_pkg::CYL_W-1:0]  cyl;
    logic                         typed;
    logic [clook_pkg::MOVE_W-1:0] typed_total;
  } stim_row_t;

  typedef struct packed {
    logic [clook_pkg::CYL_W-1:0]  cyl;
    logic [clook_pkg::MOVE_W-1:0] total;
    logic                         last;
  } served_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_command;
  logic [clook_pkg::CYL_W-1:0]  in_cylinder;
  logic                         out_valid;
  logic                         out_stall;
  logic [clook_pkg::CYL_W-1:0]  out_served_cylinder;
  logic [clook_pkg::MOVE_W-1:0] out_total_movement;
  logic                         out_last;

  logic [clook_pkg::CYL_W-1:0] req_cyl [clook_pkg::MAX_REQUESTS_DEF];
  int                          req_count;
  served_t                     service_q [$];

  int fail_count;
  int items_sent;
  int loads_dropped;
  int schedules_run;
  int served_checked;
  bit quiet;
  bit hold_pending;

  // typed rows: runs on an empty store serve the head alone
  stim_row_t directed_rows [DIRECTED_N] = '{
    '{clook_pkg::CMD_RUN,  16'd0,     1'b1, 18'd0},
    '{clook_pkg::CMD_RUN,  16'd65535, 1'b1, 18'd0},
    '{clook_pkg::CMD_LOAD, 16'd0,     1'b0, 18'd0},
    '{clook_pkg::CMD_LOAD, 16'd65535, 1'b0, 18'd0},
    '{clook_pkg::CMD_RUN,  16'd32768, 1'b0, 18'd0},
    '{clook_pkg::CMD_LOAD, 16'd100,   1'b0, 18'd0},
    '{clook_pkg::CMD_LOAD, 16'd200,   1'b0, 18'd0},
    '{clook_pkg::CMD_LOAD, 16'd300,   1'b0, 18'd0},
    '{clook_pkg::CMD_RUN,  16'd50,    1'b0, 18'd0},
    '{clook_pkg::CMD_LOAD, 16'd10,    1'b0, 18'd0},
    '{clook_pkg::CMD_LOAD, 16'd20,    1'b0, 18'd0},
    '{clook_pkg::CMD_RUN,  16'd500,   1'b0, 18'd0},
    '{clook_pkg::CMD_LOAD, 16'd7,     1'b0, 18'd0},
    '{clook_pkg::CMD_LOAD, 16'd7,     1'b0, 18'd0},
    '{clook_pkg::CMD_RUN,  16'd7,     1'b0, 18'd0},
    '{clook_pkg::CMD_LOAD, 16'd65535, 1'b0, 18'd0},
    '{clook_pkg::CMD_LOAD, 16'd0,     1'b0, 18'd0},
    '{clook_pkg::CMD_LOAD, 16'd65535, 1'b0, 18'd0},
    '{clook_pkg::CMD_RUN,  16'd1,     1'b0, 18'd0}
  };

  clook_disk_request_scheduler uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_cylinder         (in_cylinder),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_served_cylinder (out_served_cylinder),
    .out_total_movement  (out_total_movement),
    .out_last            (out_last)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // c-look service order for the held requests, head first; empties the store
  function automatic void plan_clook_order(input logic [clook_pkg::CYL_W-1:0] head);
    int unsigned                 srt [clook_pkg::MAX_REQUESTS_DEF];
    logic [clook_pkg::CYL_W-1:0] order_q [$];
    int unsigned                 key;
    int unsigned                 total;
    int unsigned                 step;
    int                          n;
    int                          below;
    int                          i;
    int                          j;
    served_t                     s;
    n = req_count;
    for (i = 0; i < n; i++) srt[i] = req_cyl[i];
    for (i = 1; i < n; i++) begin
      key = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > key) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    below = 0;
    while (below < n && srt[below] < head) below++;
    order_q.push_back(head);
    if (n - below > below) begin
      for (i = below; i < n; i++) order_q.push_back(clook_pkg::CYL_W'(srt[i]));
      for (i = 0; i < below; i++) order_q.push_back(clook_pkg::CYL_W'(srt[i]));
    end else begin
      for (i = below - 1; i >= 0; i--) order_q.push_back(clook_pkg::CYL_W'(srt[i]));
      for (i = n - 1; i >= below; i--) order_q.push_back(clook_pkg::CYL_W'(srt[i]));
    end
    total = 0;
    for (i = 1; i < order_q.size(); i++) begin
      step = (order_q[i] > order_q[i-1]) ? order_q[i] - order_q[i-1]
                                         : order_q[i-1] - order_q[i];
      total = total + step;
      if (total > clook_pkg::MOVE_MAX) total = clook_pkg::MOVE_MAX;
    end
    for (i = 0; i < order_q.size(); i++) begin
      s.cyl   = order_q[i];
      s.last  = (i == order_q.size() - 1);
      s.total = s.last ? clook_pkg::MOVE_W'(total) : '0;
      service_q.push_back(s);
    end
    req_count = 0;
  endfunction

  task automatic send_item(input logic cmd, input logic [clook_pkg::CYL_W-1:0] cyl,
                           input logic typed,
                           input logic [clook_pkg::MOVE_W-1:0] typed_total);
    served_t s;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_cylinder <= cyl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (cmd == clook_pkg::CMD_LOAD) begin
      if (req_count < clook_pkg::MAX_REQUESTS_DEF) begin
        req_cyl[req_count] = cyl;
        req_count++;
      end else begin
        loads_dropped++;
      end
    end else begin
      schedules_run++;
      if (typed) begin
        s.cyl   = cyl;
        s.total = typed_total;
        s.last  = 1'b1;
        service_q.push_back(s);
        req_count = 0;
      end else begin
        plan_clook_order(cyl);
      end
    end
    @(negedge clk);
  endtask

  // result side: random stall bursts plus one long hold-off
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_pending && out_valid) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    served_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (service_q.size() == 0) begin
        $error("unexpected transfer: served_cylinder %0d", out_served_cylinder);
        fail_count++;
      end else begin
        want = service_q.pop_front();
        served_checked++;
        if (out_served_cylinder !== want.cyl) begin
          $error("served_cylinder expected %0d actual %0d", want.cyl, out_served_cylinder);
          fail_count++;
        end
        if (out_total_movement !== want.total) begin
          $error("total_movement expected %0d actual %0d", want.total, out_total_movement);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int                          r;
    int                          k;
    int                          n_loads;
    int                          seq_idx;
    bit                          narrow;
    logic [clook_pkg::CYL_W-1:0] cyl;
    logic [clook_pkg::CYL_W-1:0] last_load;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = clook_pkg::CMD_LOAD;
    in_cylinder    = '0;
    req_count      = 0;
    fail_count     = 0;
    items_sent     = 0;
    loads_dropped  = 0;
    schedules_run  = 0;
    served_checked = 0;
    quiet          = 1'b0;
    hold_pending   = 1'b0;
    last_load      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (r = 0; r < DIRECTED_N; r++) begin
      send_item(directed_rows[r].cmd, directed_rows[r].cyl,
                directed_rows[r].typed, directed_rows[r].typed_total);
    end

    seq_idx = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (seq_idx == 3) n_loads = 8;
      else if ($urandom_range(0, 9) == 0) n_loads = $urandom_range(20, 36);
      else n_loads = $urandom_range(0, 6);
      narrow = ($urandom_range(0, 2) == 0);
      for (k = 0; k < n_loads; k++) begin
        cyl = narrow ? clook_pkg::CYL_W'($urandom_range(0, 15)) : clook_pkg::CYL_W'($urandom);
        last_load = cyl;
        send_item(clook_pkg::CMD_LOAD, cyl, 1'b0, '0);
      end
      case ($urandom_range(0, 9))
        0: cyl = '0;
        1: cyl = '1;
        2, 3: cyl = last_load;
        default: cyl = narrow ? clook_pkg::CYL_W'($urandom_range(0, 15))
                              : clook_pkg::CYL_W'($urandom);
      endcase
      // block holds mid-run so the next offered item is refused
      if (seq_idx == 3) hold_pending = 1'b1;
      send_item(clook_pkg::CMD_RUN, cyl, 1'b0, '0);
      quiet = (items_sent >= TOTAL_ITEMS - QUIET_TAIL);
      seq_idx++;
    end
    in_valid <= 1'b0;

    while (service_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d transfers in (%0d schedules, %0d loads dropped on a full store)",
             items_sent, schedules_run, loads_dropped);
    $display("checked %0d served cylinders, %0d mismatches", served_checked, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/clook_pkg.sv
rtl/clook_disk_request_scheduler.sv
sim/tb_clook_disk_request_scheduler.sv
